// ===== rtl/pwk_pkg.sv =====
// package for the two-level page walker
// types, codes and address helpers shared by the walker modules; no dependencies
`timescale 1ns / 1ps

package pwk_pkg;

  localparam logic [0:0] ITEM_REQUEST = 1'b0;
  localparam logic [0:0] ITEM_TABLE_WORD = 1'b1;

  localparam logic [1:0] RK_TABLE_READ = 2'd0;
  localparam logic [1:0] RK_PIECE = 2'd1;
  localparam logic [1:0] RK_FAULT = 2'd2;

  localparam logic [0:0] REG_PAGING_ENABLE = 1'b0;
  localparam logic [0:0] REG_PAGE_DIR_BASE = 1'b1;

  localparam int CFG_DATA_W = 20;

  // output queue depth; pointers wrap, so this stays a power of two
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PDE  = 3'b010,
    PH_PTE  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] vaddr;
    logic [2:0]  length;
    logic        write;
    logic        split;
    logic [1:0]  byte_index;
  } walk_state_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [2:0]  piece_length;
    logic [1:0]  byte_position;
    logic        access_is_write;
    logic        last;
  } result_t;

  function automatic logic [31:0] pde_addr(input logic [19:0] base, input logic [31:0] va);
    pde_addr = {base, va[31:22], 2'b00};
  endfunction

endpackage

// ===== rtl/pwk_if.sv =====
// channel interfaces for the page walker: input items and result items
// depends on nothing
`timescale 1ns / 1ps

interface pwk_in_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] vaddr;
  logic [2:0]  access_length;
  logic        is_write;
  logic [31:0] table_word;

  modport source (output valid, item_kind, vaddr, access_length, is_write, table_word,
                  input ready);
  modport sink (input valid, item_kind, vaddr, access_length, is_write, table_word,
                output ready);
endinterface

interface pwk_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] address;
  logic [2:0]  piece_length;
  logic [1:0]  byte_position;
  logic        access_is_write;
  logic        last;

  modport source (output valid, result_kind, address, piece_length, byte_position,
                  access_is_write, last, input ready);
  modport sink (input valid, result_kind, address, piece_length, byte_position,
                access_is_write, last, output ready);
endinterface

// ===== rtl/pwk_step.sv =====
// walk step logic: next walk state and up to two result words for one input word
// depends on pwk_pkg
`timescale 1ns / 1ps

module pwk_step (
  input  pwk_pkg::walk_state_t st,
  input  logic                 paging_enable,
  input  logic [19:0]          page_dir_base,
  input  logic                 item_kind,
  input  logic [31:0]          vaddr,
  input  logic [2:0]           access_length,
  input  logic                 is_write,
  input  logic [31:0]          table_word,
  output pwk_pkg::walk_state_t st_next,
  output pwk_pkg::result_t     res0,
  output pwk_pkg::result_t     res1,
  output logic [1:0]           res_count
);

  logic [2:0]  len;
  logic [31:0] end_addr;
  logic [31:0] va;
  logic [31:0] pa;
  logic [1:0]  bi_inc;
  logic [31:0] next_va;

  always_comb begin
    len = access_length;
    if (access_length == 3'd0) begin
      len = 3'd1;
    end else if (access_length > 3'd4) begin
      len = 3'd4;
    end
    end_addr = vaddr + {29'd0, len} - 32'd1;
    va = st.split ? (st.vaddr + {30'd0, st.byte_index}) : st.vaddr;
    pa = {table_word[31:12], va[11:0]};
    bi_inc = st.byte_index + 2'd1;
    next_va = st.vaddr + {30'd0, bi_inc};
  end

  always_comb begin
    st_next = st;
    res0 = '0;
    res1 = '0;
    res_count = 2'd0;
    res0.access_is_write = st.write;
    res1.access_is_write = st.write;
    if (item_kind == pwk_pkg::ITEM_REQUEST) begin
      if (st.phase == pwk_pkg::PH_IDLE) begin
        st_next.vaddr = vaddr;
        st_next.length = len;
        st_next.write = is_write;
        st_next.byte_index = 2'd0;
        st_next.split = 1'b0;
        res0.access_is_write = is_write;
        res_count = 2'd1;
        if (!paging_enable) begin
          res0.result_kind = pwk_pkg::RK_PIECE;
          res0.address = vaddr;
          res0.piece_length = len;
          res0.last = 1'b1;
        end else begin
          st_next.split = (vaddr[31:12] != end_addr[31:12]);
          st_next.phase = pwk_pkg::PH_PDE;
          res0.result_kind = pwk_pkg::RK_TABLE_READ;
          res0.address = pwk_pkg::pde_addr(page_dir_base, vaddr);
        end
      end
    end else if (st.phase != pwk_pkg::PH_IDLE) begin
      res_count = 2'd1;
      if (!table_word[0]) begin
        st_next.phase = pwk_pkg::PH_IDLE;
        res0.result_kind = pwk_pkg::RK_FAULT;
        res0.address = va;
        res0.piece_length = st.length;
        res0.byte_position = st.byte_index;
        res0.last = 1'b1;
      end else if (st.phase == pwk_pkg::PH_PDE) begin
        st_next.phase = pwk_pkg::PH_PTE;
        res0.result_kind = pwk_pkg::RK_TABLE_READ;
        res0.address = {table_word[31:12], va[21:12], 2'b00};
      end else begin
        res0.result_kind = pwk_pkg::RK_PIECE;
        res0.address = pa;
        if (!st.split) begin
          st_next.phase = pwk_pkg::PH_IDLE;
          res0.piece_length = st.length;
          res0.last = 1'b1;
        end else if ({1'b0, st.byte_index} + 3'd1 >= st.length) begin
          st_next.phase = pwk_pkg::PH_IDLE;
          res0.piece_length = 3'd1;
          res0.byte_position = st.byte_index;
          res0.last = 1'b1;
        end else begin
          res0.piece_length = 3'd1;
          res0.byte_position = st.byte_index;
          st_next.byte_index = bi_inc;
          st_next.phase = pwk_pkg::PH_PDE;
          res1.result_kind = pwk_pkg::RK_TABLE_READ;
          res1.address = pwk_pkg::pde_addr(page_dir_base, next_va);
          res_count = 2'd2;
        end
      end
    end
  end

endmodule

// ===== rtl/two_level_page_walker_top.sv =====
// Two-level page walker. Takes one input word per cycle (access request or
// returned table entry) and updates the walk state in the same cycle; the
// result words it causes go into a four-entry output queue that drains one
// word per cycle. An input word is taken whenever the queue holds at most two
// words, so the block runs at one input word per cycle as long as the output
// side takes one word per cycle; a split access step that yields a piece and
// the next directory read puts two words in the queue.
// depends on pwk_pkg, pwk_if and pwk_step
`timescale 1ns / 1ps

module two_level_page_walker_top (
  input  logic               clk,
  input  logic               rst,
  pwk_in_if.sink             item,
  pwk_out_if.source          result,
  input  logic               wr_en,
  input  logic [0:0]         wr_index,
  input  logic [pwk_pkg::CFG_DATA_W-1:0] wr_data
);

  localparam int PTR_W = $clog2(pwk_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pwk_pkg::QUEUE_DEPTH + 1);

  logic                 paging_enable;
  logic [19:0]          page_dir_base;
  pwk_pkg::walk_state_t st;
  pwk_pkg::walk_state_t st_next;
  pwk_pkg::result_t     res0;
  pwk_pkg::result_t     res1;
  logic [1:0]           res_count;

  pwk_pkg::result_t     queue [pwk_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wptr;
  logic [PTR_W-1:0]     rptr;
  logic [CNT_W-1:0]     count;
  logic                 take;
  logic                 pop;
  logic [CNT_W-1:0]     push_n;
  pwk_pkg::result_t     head;

  pwk_step u_step (
    .st            (st),
    .paging_enable (paging_enable),
    .page_dir_base (page_dir_base),
    .item_kind     (item.item_kind),
    .vaddr         (item.vaddr),
    .access_length (item.access_length),
    .is_write      (item.is_write),
    .table_word    (item.table_word),
    .st_next       (st_next),
    .res0          (res0),
    .res1          (res1),
    .res_count     (res_count)
  );

  assign item.ready = (count <= CNT_W'(pwk_pkg::QUEUE_DEPTH - 2));
  assign take = item.valid && item.ready;
  assign pop = result.valid && result.ready;
  assign push_n = take ? CNT_W'(res_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enable <= 1'b0;
      page_dir_base <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pwk_pkg::REG_PAGING_ENABLE: paging_enable <= wr_data[0];
        pwk_pkg::REG_PAGE_DIR_BASE: page_dir_base <= wr_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= pwk_pkg::PH_IDLE;
      st.vaddr <= '0;
      st.length <= 3'd1;
      st.write <= 1'b0;
      st.split <= 1'b0;
      st.byte_index <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_count != 2'd0) begin
      queue[wptr] <= res0;
    end
    if (take && res_count == 2'd2) begin
      queue[wptr + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + PTR_W'(push_n);
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

  assign head = queue[rptr];
  assign result.valid = (count != '0);
  assign result.result_kind = head.result_kind;
  assign result.address = head.address;
  assign result.piece_length = head.piece_length;
  assign result.byte_position = head.byte_position;
  assign result.access_is_write = head.access_is_write;
  assign result.last = head.last;

endmodule

// ===== rtl/pwk_checker.sv =====
// port-level checks for the page walker, bound to the top level
// depends on pwk_pkg and two_level_page_walker_top
`timescale 1ns / 1ps

module pwk_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [2:0]  piece_length,
  input logic [1:0]  byte_position,
  input logic        last
);

  // queue is empty right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a table read never closes an access and carries no length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == pwk_pkg::RK_TABLE_READ |->
      !last && piece_length == 3'd0 && byte_position == 2'd0)
    else $error("bad table read word");

  // faults always end the access
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == pwk_pkg::RK_FAULT |-> last && piece_length != 3'd0)
    else $error("fault without last");

  // pieces cover one to four bytes and stay inside the access data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == pwk_pkg::RK_PIECE |->
      piece_length != 3'd0 && piece_length <= 3'd4 &&
      ({1'b0, byte_position} + piece_length <= 3'd4))
    else $error("bad piece length");

  // a stalled word stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind two_level_page_walker_top pwk_checker u_pwk_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .result_kind   (result.result_kind),
  .piece_length  (result.piece_length),
  .byte_position (result.byte_position),
  .last          (result.last)
);
